FILE: rtl/core/bfsam_pkg.sv
// Shared constants, codes and beat types for the BFS adjacency matrix unit.
`timescale 1ns / 1ps

package bfsam_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int CAPACITY     = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
    localparam int VTX_W        = 5;
    localparam int CNT_W        = 6;
    localparam int LABEL_W      = 8;
    localparam int WEIGHT_W     = 16;

    localparam logic [WEIGHT_W-1:0] NO_EDGE = 16'hFFFF;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_EDGE  = 2'd1;
    localparam logic [1:0] CMD_LABEL = 2'd2;
    localparam logic [1:0] CMD_RUN   = 2'd3;

    localparam logic REG_VERTEX_COUNT = 1'b0;

    typedef struct packed {
        logic [1:0]          command;
        logic [VTX_W-1:0]    vertex_a;
        logic [VTX_W-1:0]    vertex_b;
        logic [WEIGHT_W-1:0] weight;
        logic [LABEL_W-1:0]  label;
    } t_in_item;

    typedef struct packed {
        logic [VTX_W-1:0]   vertex;
        logic [LABEL_W-1:0] label_res;
        logic               last;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;     // apply a clear, edge or label beat
        logic init;     // start a run
        logic next_s;   // advance start vertex
        logic visit_s;  // visit start vertex
        logic pop;      // dequeue a vertex and latch its row
        logic step;     // examine neighbor j
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic s_done;
        logic s_seen;
        logic q_empty;
        logic j_done;
    } t_dp_stat;

endpackage

FILE: rtl/core/bfsam_ctrl.sv
// Sequencer for load commands and the breadth-first traversal.
`timescale 1ns / 1ps

module bfsam_ctrl
    import bfsam_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic [1:0] i_command,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_DEQ   = 2'd2;
    localparam logic [1:0] S_SCAN  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_busy = (r_state != S_IDLE);
    assign accept = i_start && !o_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_command == CMD_RUN) begin
                        o_cmd.init = 1'b1;
                        n_state    = S_START;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_START: begin
                if (i_stat.s_done) begin
                    n_state = S_IDLE;
                end else if (i_stat.s_seen) begin
                    o_cmd.next_s = 1'b1;
                end else begin
                    o_cmd.visit_s = 1'b1;
                    n_state       = S_DEQ;
                end
            end
            S_DEQ: begin
                if (i_stat.q_empty) begin
                    o_cmd.next_s = 1'b1;
                    n_state      = S_START;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.j_done) begin
                    n_state = S_DEQ;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/core/bfsam_datapath.sv
// Graph storage, visit queue, scan counters and result register.
`timescale 1ns / 1ps

module bfsam_datapath
    import bfsam_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  t_in_item         i_item,
    input  logic [CNT_W-1:0] i_vertex_count,
    output t_dp_stat         o_stat,
    output logic             o_res_valid,
    output t_out_item        o_res
);

    localparam logic [CNT_W-1:0] CAP_N = CNT_W'(CAPACITY);

    logic [CAPACITY-1:0] r_adj [0:CAPACITY-1];
    logic [LABEL_W-1:0]  r_label [0:CAPACITY-1];
    logic [VTX_W-1:0]    r_queue [0:CAPACITY-1];
    logic [CAPACITY-1:0] r_visited;
    logic [CAPACITY-1:0] r_row;
    logic [CNT_W-1:0]    r_head;
    logic [CNT_W-1:0]    r_tail;
    logic [CNT_W-1:0]    r_s;
    logic [CNT_W-1:0]    r_j;
    logic [CNT_W-1:0]    r_n;
    logic [CNT_W-1:0]    r_count;
    logic                r_res_valid;
    t_out_item           r_res;

    logic [CNT_W-1:0] n_count;
    logic             hit;
    logic             vis_en;
    logic [VTX_W-1:0] vis_idx;
    logic             edge_on;

    assign hit     = r_row[r_j[VTX_W-1:0]] && !r_visited[r_j[VTX_W-1:0]];
    assign vis_en  = i_cmd.visit_s || (i_cmd.step && hit);
    assign vis_idx = i_cmd.visit_s ? r_s[VTX_W-1:0] : r_j[VTX_W-1:0];
    assign n_count = CNT_W'(r_count + 1'b1);
    assign edge_on = (i_item.weight < NO_EDGE);

    assign o_stat.s_done  = (r_s == r_n);
    assign o_stat.s_seen  = r_visited[r_s[VTX_W-1:0]];
    assign o_stat.q_empty = (r_head == r_tail);
    assign o_stat.j_done  = (r_j == r_n);

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // adjacency: clear removes every edge at once, an edge beat writes both directions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < CAPACITY; r++) begin
                r_adj[r] <= '0;
            end
        end else if (i_cmd.load) begin
            case (i_item.command)
                CMD_CLEAR: begin
                    for (int r = 0; r < CAPACITY; r++) begin
                        r_adj[r] <= '0;
                    end
                end
                CMD_EDGE: begin
                    r_adj[i_item.vertex_a][i_item.vertex_b] <= edge_on;
                    r_adj[i_item.vertex_b][i_item.vertex_a] <= edge_on;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < CAPACITY; r++) begin
                r_label[r] <= '0;
            end
        end else if (i_cmd.load && i_item.command == CMD_LABEL) begin
            r_label[i_item.vertex_a] <= i_item.label;
        end
    end

    always_ff @(posedge i_clk) begin
        if (vis_en) begin
            r_queue[r_tail[VTX_W-1:0]] <= vis_idx;
        end
        if (i_cmd.pop) begin
            r_row <= r_adj[r_queue[r_head[VTX_W-1:0]]];
        end
        r_res.vertex    <= vis_idx;
        r_res.label_res <= r_label[vis_idx];
        r_res.last      <= (n_count == r_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visited   <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_s         <= '0;
            r_j         <= '0;
            r_n         <= '0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= vis_en;
            if (i_cmd.init) begin
                r_visited <= '0;
                r_head    <= '0;
                r_tail    <= '0;
                r_s       <= '0;
                r_count   <= '0;
                r_n       <= (i_vertex_count > CAP_N) ? CAP_N : i_vertex_count;
            end
            if (i_cmd.next_s) begin
                r_s <= CNT_W'(r_s + 1'b1);
            end
            if (i_cmd.pop) begin
                r_head <= CNT_W'(r_head + 1'b1);
                r_j    <= '0;
            end
            if (i_cmd.step) begin
                r_j <= CNT_W'(r_j + 1'b1);
            end
            if (vis_en) begin
                r_visited[vis_idx] <= 1'b1;
                r_tail             <= CNT_W'(r_tail + 1'b1);
                r_count            <= n_count;
            end
        end
    end

    a_head_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("queue head passed tail");

    a_last_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.last) |-> (r_count == r_n))
        else $error("last beat before every vertex was visited");

    a_visit_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vis_en |-> !r_visited[vis_idx])
        else $error("vertex visited twice");

endmodule

FILE: rtl/core/bfs_adjacency_matrix_unit.sv
// Top level: APB register, command sequencer and traversal datapath.
`timescale 1ns / 1ps

// Breadth-first search over an undirected graph of up to 32 vertices held as an
// adjacency bit matrix with a byte label per vertex. A command beat is taken when
// start is high and busy is low. Clear, edge and label beats leave busy low, so
// they can follow back to back. A run raises busy until the traversal of
// n = min(vertex_count, 32) vertices is over; the scan of each dequeued vertex's
// row examines one neighbor per cycle. Each visited vertex comes out as one
// result beat on o_res, flagged by o_res_valid for a single cycle; the receiver
// cannot stall, so it must take every beat as it appears. The final beat of a run
// carries last. vertex_count is written over APB at address 0; the user must
// write it only while busy is low, the block itself does not enforce it.

module bfs_adjacency_matrix_unit
    import bfsam_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_item    i_item,
    output logic        o_res_valid,
    output t_out_item   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CNT_W-1:0] r_vertex_count;
    logic             cfg_wr;
    t_dp_cmd          dp_cmd;
    t_dp_stat         dp_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? 32'(r_vertex_count) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= '0;
        end else if (cfg_wr && paddr[2] == REG_VERTEX_COUNT) begin
            r_vertex_count <= pwdata[CNT_W-1:0];
        end
    end

    bfsam_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_item.command),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd),
        .o_busy    (busy)
    );

    bfsam_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_item         (i_item),
        .i_vertex_count (r_vertex_count),
        .o_stat         (dp_stat),
        .o_res_valid    (o_res_valid),
        .o_res          (o_res)
    );

endmodule
